/* sv/assert_macros.svh */
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/cppm_pkg.sv */
// Package with the palette, register indexes and shared types of the pixel mapper.
package cppm_pkg;

  localparam int PAL_SIZE = 7;
  localparam int IDX_W = 3;
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COORD_W = 16;
  localparam int PANEL_W = 12;
  localparam int PIPE_DEPTH = 5;

  typedef logic [7:0] chan_t;
  typedef logic [IDX_W-1:0] pal_idx_t;
  typedef logic [18:0] dist_t;

  localparam logic [REG_IDX_W-1:0] REG_DRAW_EN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMG_W = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMG_H = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_W = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_H = 3'd4;

  localparam logic [PANEL_W-1:0] PANEL_W_RESET = 12'd800;
  localparam logic [PANEL_W-1:0] PANEL_H_RESET = 12'd480;

  // Palette entries: black, white, red, yellow, orange, green, blue.
  localparam chan_t PAL_R [PAL_SIZE] = '{8'd0, 8'd255, 8'd200, 8'd255, 8'd255, 8'd0, 8'd0};
  localparam chan_t PAL_G [PAL_SIZE] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd180, 8'd0};
  localparam chan_t PAL_B [PAL_SIZE] = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd200};

  localparam pal_idx_t PAL_LAST = pal_idx_t'(PAL_SIZE - 1);

endpackage

/* sv/centered_palette_pixel_mapper.sv */
// Top level of the centered palette pixel mapper: placement and nearest-color pipeline.
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ---------------------------------------
//  pixel     in         start / busy         pixel_x, pixel_y, red, green, blue
//  result    out        done strobe          panel_x, panel_y, palette_index
//  config    in         wr_en                wr_index, wr_data
//
// One pixel is accepted every clock cycle; busy never rises. A result passes through
// the operand and offset stage, square stage, weighted sum stage, first compare stage
// and final compare stage. A pixel that misses the image or the panel or arrives while
// drawing is disabled gives no done pulse. Synchronous reset clears the valid bits and
// returns the registers to their reset values.
module centered_palette_pixel_mapper
  import cppm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_W-1:0]    pixel_x,
  input  logic [COORD_W-1:0]    pixel_y,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output logic                  done,
  output logic [PANEL_W-1:0]    panel_x,
  output logic [PANEL_W-1:0]    panel_y,
  output logic [IDX_W-1:0]      palette_index
);

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    abs_diff = (a > b) ? chan_t'(a - b) : chan_t'(b - a);
  endfunction

  logic                 drawing_enabled;
  logic [COORD_W-1:0]   image_width;
  logic [COORD_W-1:0]   image_height;
  logic [PANEL_W-1:0]   panel_width;
  logic [PANEL_W-1:0]   panel_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      drawing_enabled <= 1'b0;
      image_width     <= '0;
      image_height    <= '0;
      panel_width     <= PANEL_W_RESET;
      panel_height    <= PANEL_H_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_DRAW_EN: drawing_enabled <= wr_data[0];
        REG_IMG_W:   image_width     <= wr_data;
        REG_IMG_H:   image_height    <= wr_data;
        REG_PANEL_W: panel_width     <= wr_data[PANEL_W-1:0];
        REG_PANEL_H: panel_height    <= wr_data[PANEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: image bounds, centering offsets and per-entry channel distances.
  logic [COORD_W-1:0]  span_x, span_y;
  logic [PANEL_W-2:0]  off_x, off_y;
  logic                in_image;

  always_comb begin
    span_x = {{(COORD_W-PANEL_W){1'b0}}, panel_width} - image_width;
    span_y = {{(COORD_W-PANEL_W){1'b0}}, panel_height} - image_height;
    off_x = ({{(COORD_W-PANEL_W){1'b0}}, panel_width} > image_width) ?
            span_x[PANEL_W-1:1] : '0;
    off_y = ({{(COORD_W-PANEL_W){1'b0}}, panel_height} > image_height) ?
            span_y[PANEL_W-1:1] : '0;
    in_image = drawing_enabled && (pixel_x < image_width) && (pixel_y < image_height);
  end

  logic               s1_valid;
  logic [COORD_W-1:0] s1_x, s1_y;
  logic [PANEL_W-2:0] s1_off_x, s1_off_y;
  chan_t              s1_dr [PAL_SIZE];
  chan_t              s1_dg [PAL_SIZE];
  chan_t              s1_db [PAL_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy && in_image;
    end
  end

  always_ff @(posedge clk) begin
    s1_x     <= pixel_x;
    s1_y     <= pixel_y;
    s1_off_x <= off_x;
    s1_off_y <= off_y;
    for (int i = 0; i < PAL_SIZE; i++) begin
      s1_dr[i] <= abs_diff(red, PAL_R[i]);
      s1_dg[i] <= abs_diff(green, PAL_G[i]);
      s1_db[i] <= abs_diff(blue, PAL_B[i]);
    end
  end

  // Stage 2: placed position, panel bounds and squared channel distances.
  logic [COORD_W:0] pos_x, pos_y;
  logic             on_panel;

  always_comb begin
    pos_x = {1'b0, s1_x} + {{(COORD_W-PANEL_W+2){1'b0}}, s1_off_x};
    pos_y = {1'b0, s1_y} + {{(COORD_W-PANEL_W+2){1'b0}}, s1_off_y};
    on_panel = (pos_x < {{(COORD_W-PANEL_W+1){1'b0}}, panel_width}) &&
               (pos_y < {{(COORD_W-PANEL_W+1){1'b0}}, panel_height});
  end

  logic               s2_valid;
  logic [PANEL_W-1:0] s2_px, s2_py;
  logic [15:0]        s2_sr [PAL_SIZE];
  logic [15:0]        s2_sg [PAL_SIZE];
  logic [15:0]        s2_sb [PAL_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && on_panel;
    end
  end

  always_ff @(posedge clk) begin
    s2_px <= pos_x[PANEL_W-1:0];
    s2_py <= pos_y[PANEL_W-1:0];
    for (int i = 0; i < PAL_SIZE; i++) begin
      s2_sr[i] <= {8'd0, s1_dr[i]} * {8'd0, s1_dr[i]};
      s2_sg[i] <= {8'd0, s1_dg[i]} * {8'd0, s1_dg[i]};
      s2_sb[i] <= {8'd0, s1_db[i]} * {8'd0, s1_db[i]};
    end
  end

  // Stage 3: weighted distance 2*dR^2 + 4*dG^2 + dB^2 for every entry.
  logic               s3_valid;
  logic [PANEL_W-1:0] s3_px, s3_py;
  dist_t              s3_dist [PAL_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_px <= s2_px;
    s3_py <= s2_py;
    for (int i = 0; i < PAL_SIZE; i++) begin
      s3_dist[i] <= {2'b00, s2_sr[i], 1'b0} + {1'b0, s2_sg[i], 2'b00} +
                    {3'b000, s2_sb[i]};
    end
  end

  // Stage 4: first level of the minimum tree. The later entry of a pair wins only
  // when strictly closer, so ties keep the lower index all the way up.
  logic               s4_valid;
  logic [PANEL_W-1:0] s4_px, s4_py;
  dist_t              s4_dist [4];
  pal_idx_t           s4_idx [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_px <= s3_px;
    s4_py <= s3_py;
    for (int p = 0; p < 3; p++) begin
      if (s3_dist[2*p+1] < s3_dist[2*p]) begin
        s4_dist[p] <= s3_dist[2*p+1];
        s4_idx[p]  <= pal_idx_t'(2*p+1);
      end else begin
        s4_dist[p] <= s3_dist[2*p];
        s4_idx[p]  <= pal_idx_t'(2*p);
      end
    end
    s4_dist[3] <= s3_dist[PAL_SIZE-1];
    s4_idx[3]  <= PAL_LAST;
  end

  // Stage 5: last two tree levels and the output register.
  dist_t    lo_dist, hi_dist;
  pal_idx_t lo_idx, hi_idx, best_idx;

  always_comb begin
    lo_dist = (s4_dist[1] < s4_dist[0]) ? s4_dist[1] : s4_dist[0];
    lo_idx  = (s4_dist[1] < s4_dist[0]) ? s4_idx[1] : s4_idx[0];
    hi_dist = (s4_dist[3] < s4_dist[2]) ? s4_dist[3] : s4_dist[2];
    hi_idx  = (s4_dist[3] < s4_dist[2]) ? s4_idx[3] : s4_idx[2];
    best_idx = (hi_dist < lo_dist) ? hi_idx : lo_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    panel_x       <= s4_px;
    panel_y       <= s4_py;
    palette_index <= best_idx;
  end

endmodule

/* sv/cppm_checker.sv */
// Port-level checker for the centered palette pixel mapper, bound to the top level.
`include "assert_macros.svh"

module cppm_checker
  import cppm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic [PANEL_W-1:0]    panel_x,
  input logic [PANEL_W-1:0]    panel_y,
  input logic [IDX_W-1:0]      palette_index
);

  // A result can only follow an earlier accepted transaction.
  `ASSERT_CLKD(a_done_has_source, clk, rst, done |-> $past(start && !busy, PIPE_DEPTH), "done without an accepted transaction")

  `ASSERT_CLKD(a_index_in_palette, clk, rst, done |-> (palette_index <= PAL_LAST), "palette index beyond the palette")

  `ASSERT_CLKD(a_position_on_panel, clk, rst, done |-> ((panel_x != '1) && (panel_y != '1)), "placed position beyond the largest panel")

  // The pipeline never holds off the pixel stream, reset included.
  `ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")

  // Reset empties the pipeline, so no done right after it.
  `ASSERT_ALWAYS(a_reset_flushes, clk, $past(rst) |-> !done, "done right after reset")

endmodule

bind centered_palette_pixel_mapper cppm_checker u_cppm_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .panel_x       (panel_x),
  .panel_y       (panel_y),
  .palette_index (palette_index)
);

/* sim/tb.sv */
// Self-checking testbench for the centered palette pixel mapper.
module tb;

  localparam int PIPE_LAT = cppm_pkg::PIPE_DEPTH;
  localparam int PHASES = 10;
  localparam int PIXELS_PER_PHASE = 125;
  localparam logic [cppm_pkg::REG_IDX_W-1:0] REG_SPARE_LO = cppm_pkg::REG_PANEL_H + 3'd1;
  localparam logic [cppm_pkg::REG_IDX_W-1:0] REG_SPARE_HI = '1;

  typedef enum logic [2:0] {
    C_BLACK, C_WHITE, C_RED, C_YELLOW, C_ORANGE, C_GREEN, C_BLUE
  } color_e;

  typedef enum logic [1:0] {OP_PIXEL, OP_WRITE, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e    kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [2:0]  idx;
    logic [15:0] data;
    int          idle_pct;
  } op_t;

  typedef struct {
    logic [11:0] px;
    logic [11:0] py;
    logic [2:0]  color;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] pixel_x = '0;
  logic [15:0] pixel_y = '0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [15:0] wr_data = '0;
  logic        done;
  logic [11:0] panel_x;
  logic [11:0] panel_y;
  logic [2:0]  palette_index;

  // Local copy of the register file.
  logic        draw_en;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [11:0] pnl_w;
  logic [11:0] pnl_h;

  op_t        pending_ops[$];
  placement_t placements_due[$];
  int         fails = 0;
  int         settle = 0;
  int         idle_now = 0;
  op_t        cur_op;
  logic       go;
  logic       wr;

  centered_palette_pixel_mapper dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .red(red), .green(green), .blue(blue),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .panel_x(panel_x), .panel_y(panel_y), .palette_index(palette_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [23:0] palette_rgb(color_e c);
    case (c)
      C_BLACK:  return {8'd0,   8'd0,   8'd0};
      C_WHITE:  return {8'd255, 8'd255, 8'd255};
      C_RED:    return {8'd200, 8'd0,   8'd0};
      C_YELLOW: return {8'd255, 8'd255, 8'd0};
      C_ORANGE: return {8'd255, 8'd128, 8'd0};
      C_GREEN:  return {8'd0,   8'd180, 8'd0};
      default:  return {8'd0,   8'd0,   8'd200};
    endcase
  endfunction

  // Strict less-than keeps the lower entry on a tie.
  function automatic color_e nearest_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    color_e      best;
    int          best_dist;
    int          wdist;
    int          dr;
    int          dg;
    int          db;
    logic [23:0] rgb;
    best = C_BLACK;
    best_dist = 0;
    for (int i = 0; i <= int'(C_BLUE); i++) begin
      rgb = palette_rgb(color_e'(i));
      dr = int'(r) - int'(rgb[23:16]);
      dg = int'(g) - int'(rgb[15:8]);
      db = int'(b) - int'(rgb[7:0]);
      wdist = 2 * dr * dr + 4 * dg * dg + db * db;
      if (i == 0 || wdist < best_dist) begin
        best_dist = wdist;
        best = color_e'(i);
      end
    end
    return best;
  endfunction

  function automatic int center_offset(int pnl, int img);
    return (pnl > img) ? (pnl - img) / 2 : 0;
  endfunction

  task automatic set_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      cppm_pkg::REG_DRAW_EN: draw_en = data[0];
      cppm_pkg::REG_IMG_W:   img_w = data;
      cppm_pkg::REG_IMG_H:   img_h = data;
      cppm_pkg::REG_PANEL_W: pnl_w = data[11:0];
      cppm_pkg::REG_PANEL_H: pnl_h = data[11:0];
      default: ;
    endcase
  endtask

  task automatic map_pixel(logic [15:0] x, logic [15:0] y, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
    int         px;
    int         py;
    placement_t p;
    if (!draw_en || x >= img_w || y >= img_h) return;
    px = center_offset(int'(pnl_w), int'(img_w)) + int'(x);
    py = center_offset(int'(pnl_h), int'(img_h)) + int'(y);
    if (px >= int'(pnl_w) || py >= int'(pnl_h)) return;
    p.px = px[11:0];
    p.py = py[11:0];
    p.color = nearest_color(r, g, b);
    placements_due.push_back(p);
  endtask

  task automatic add_pixel(int x, int y, int r, int g, int b);
    op_t o;
    o.kind = OP_PIXEL;
    o.x = x[15:0];
    o.y = y[15:0];
    o.r = r[7:0];
    o.g = g[7:0];
    o.b = b[7:0];
    o.idx = '0;
    o.data = '0;
    o.idle_pct = idle_now;
    pending_ops.push_back(o);
  endtask

  task automatic add_write(logic [2:0] idx, logic [15:0] data);
    op_t o;
    o.kind = OP_WRITE;
    o.x = '0;
    o.y = '0;
    o.r = '0;
    o.g = '0;
    o.b = '0;
    o.idx = idx;
    o.data = data;
    o.idle_pct = 0;
    pending_ops.push_back(o);
  endtask

  task automatic add_drain();
    op_t o;
    o.kind = OP_DRAIN;
    o.x = '0;
    o.y = '0;
    o.r = '0;
    o.g = '0;
    o.b = '0;
    o.idx = '0;
    o.data = '0;
    o.idle_pct = 0;
    pending_ops.push_back(o);
  endtask

  function automatic int rand_channel();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Driver: the transaction presented now is taken at this edge if busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      if (start && !busy) map_pixel(pixel_x, pixel_y, red, green, blue);
      go = start && busy;
      wr = 1'b0;
      if (!go) begin
        if (settle > 0) begin
          settle = settle - 1;
        end else if (pending_ops.size() != 0) begin
          cur_op = pending_ops[0];
          case (cur_op.kind)
            OP_PIXEL: begin
              if ($urandom_range(99) >= cur_op.idle_pct) begin
                go = 1'b1;
                pixel_x <= cur_op.x;
                pixel_y <= cur_op.y;
                red <= cur_op.r;
                green <= cur_op.g;
                blue <= cur_op.b;
                void'(pending_ops.pop_front());
              end
            end
            OP_WRITE: begin
              wr = 1'b1;
              wr_index <= cur_op.idx;
              wr_data <= cur_op.data;
              set_reg(cur_op.idx, cur_op.data);
              void'(pending_ops.pop_front());
            end
            default: begin
              // Pixels that give no result may still be in the pipeline.
              if (placements_due.size() == 0) begin
                settle = PIPE_LAT + 2;
                void'(pending_ops.pop_front());
              end
            end
          endcase
        end
      end
      start <= go;
      wr_en <= wr;
    end
  end

  // Monitor: every done pulse is one result transaction.
  always @(posedge clk) begin
    placement_t e;
    if (!rst && done) begin
      if (placements_due.size() == 0) begin
        $display("%0t: unexpected result panel_x %0d panel_y %0d palette_index %0d",
                 $time, panel_x, panel_y, palette_index);
        fails = fails + 1;
      end else begin
        e = placements_due.pop_front();
        if (panel_x !== e.px) begin
          $display("%0t: panel_x expected %0d actual %0d", $time, e.px, panel_x);
          fails = fails + 1;
        end
        if (panel_y !== e.py) begin
          $display("%0t: panel_y expected %0d actual %0d", $time, e.py, panel_y);
          fails = fails + 1;
        end
        if (palette_index !== e.color) begin
          $display("%0t: palette_index expected %0d actual %0d", $time, e.color,
                   palette_index);
          fails = fails + 1;
        end
      end
    end
  end

  initial begin
    int          pw;
    int          ph;
    int          iw;
    int          ih;
    int          x;
    int          y;
    logic [23:0] rgb;
    int          idle_pattern[4];

    idle_pattern[0] = 0;
    idle_pattern[1] = 68;
    idle_pattern[2] = 0;
    idle_pattern[3] = 34;

    draw_en = 1'b0;
    img_w = '0;
    img_h = '0;
    pnl_w = cppm_pkg::PANEL_W_RESET;
    pnl_h = cppm_pkg::PANEL_H_RESET;

    // Drawing is off after reset.
    add_pixel(0, 0, 255, 255, 255);
    add_drain();
    add_write(cppm_pkg::REG_DRAW_EN, 16'd1);
    add_write(cppm_pkg::REG_IMG_W, 16'd100);
    add_write(cppm_pkg::REG_IMG_H, 16'd50);
    for (int i = 0; i <= int'(C_BLUE); i++) begin
      rgb = palette_rgb(color_e'(i));
      add_pixel(i, 0, rgb[23:16], rgb[15:8], rgb[7:0]);
    end
    add_pixel(99, 49, 255, 255, 255);
    // Equal distances to black and red, then to black and blue.
    add_pixel(1, 1, 100, 0, 0);
    add_pixel(2, 1, 0, 0, 100);
    add_pixel(100, 0, 10, 20, 30);
    add_pixel(0, 50, 10, 20, 30);
    add_pixel(65535, 65535, 10, 20, 30);

    // Image larger than the panel: offsets clamp to zero.
    add_drain();
    add_write(cppm_pkg::REG_IMG_W, 16'hFFFF);
    add_write(cppm_pkg::REG_IMG_H, 16'hFFFF);
    add_write(cppm_pkg::REG_PANEL_W, 16'd4095);
    add_write(cppm_pkg::REG_PANEL_H, 16'd4095);
    add_pixel(4094, 4094, 255, 128, 0);
    add_pixel(4095, 0, 255, 128, 0);
    add_drain();
    add_write(cppm_pkg::REG_PANEL_W, 16'd1);
    add_write(cppm_pkg::REG_PANEL_H, 16'd1);
    add_pixel(0, 0, 0, 180, 0);
    add_pixel(1, 0, 0, 180, 0);

    // Zero panel width, then zero image width.
    add_drain();
    add_write(cppm_pkg::REG_PANEL_W, 16'd0);
    add_pixel(0, 0, 0, 0, 200);
    add_drain();
    add_write(cppm_pkg::REG_PANEL_W, 16'hF320);
    add_write(cppm_pkg::REG_PANEL_H, 16'hA1E0);
    add_write(cppm_pkg::REG_IMG_W, 16'd0);
    add_pixel(0, 0, 0, 0, 200);
    add_drain();
    add_write(cppm_pkg::REG_IMG_W, 16'd800);
    add_pixel(799, 0, 200, 0, 0);

    // Upper data bits are dropped and unused indexes are ignored.
    add_drain();
    add_write(cppm_pkg::REG_DRAW_EN, 16'hFFFE);
    add_pixel(0, 0, 200, 0, 0);
    add_drain();
    for (int k = int'(REG_SPARE_LO); k <= int'(REG_SPARE_HI); k++)
      add_write(k[2:0], 16'hFFFF);
    add_write(cppm_pkg::REG_DRAW_EN, 16'h0001);
    add_pixel(0, 0, 255, 255, 0);

    // Largest offset: a one-pixel image on the largest panel.
    add_drain();
    add_write(cppm_pkg::REG_PANEL_W, 16'd4095);
    add_write(cppm_pkg::REG_PANEL_H, 16'd4095);
    add_write(cppm_pkg::REG_IMG_W, 16'd1);
    add_write(cppm_pkg::REG_IMG_H, 16'd1);
    add_pixel(0, 0, 128, 128, 128);

    for (int ph_i = 0; ph_i < PHASES; ph_i++) begin
      add_drain();
      idle_now = idle_pattern[ph_i % 4];
      pw = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 1 : 4095)
                                    : $urandom_range(4095, 1);
      ph = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 1 : 4095)
                                    : $urandom_range(4095, 1);
      case ($urandom_range(9))
        0:       iw = 65535;
        1:       iw = $urandom_range(65535);
        default: iw = $urandom_range(pw + pw / 2, 1);
      endcase
      case ($urandom_range(9))
        0:       ih = 65535;
        1:       ih = $urandom_range(65535);
        default: ih = $urandom_range(ph + ph / 2, 1);
      endcase
      add_write(cppm_pkg::REG_DRAW_EN,
                {15'($urandom_range(32767)), ($urandom_range(9) != 0) ? 1'b1 : 1'b0});
      add_write(cppm_pkg::REG_IMG_W, iw[15:0]);
      add_write(cppm_pkg::REG_IMG_H, ih[15:0]);
      add_write(cppm_pkg::REG_PANEL_W, {4'($urandom_range(15)), pw[11:0]});
      add_write(cppm_pkg::REG_PANEL_H, {4'($urandom_range(15)), ph[11:0]});
      add_write(3'($urandom_range(int'(REG_SPARE_HI), int'(REG_SPARE_LO))),
                16'($urandom_range(65535)));
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        // Mostly pixels inside the image, the rest anywhere.
        x = ($urandom_range(4) != 0) ? $urandom_range(iw - 1) : $urandom_range(65535);
        y = ($urandom_range(4) != 0) ? $urandom_range(ih - 1) : $urandom_range(65535);
        add_pixel(x, y, rand_channel(), rand_channel(), rand_channel());
        if (ph_i == 3 && n == PIXELS_PER_PHASE / 2) add_drain();
      end
    end
    add_drain();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || settle != 0) @(posedge clk);
    repeat (PIPE_LAT + 3) @(posedge clk);
    if (placements_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, placements_due.size());
      fails = fails + 1;
    end
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
